FILE: design/keyed_quota_table_assert.svh
// ----------------------------------------------------------------------------
// Keyed quota table assertion macros
// Concurrent assertion wrappers used by the RTL of the quota table.
// ----------------------------------------------------------------------------
`ifndef KEYED_QUOTA_TABLE_ASSERT_SVH
`define KEYED_QUOTA_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge of clk, suspended while rst_n is low.
`define KQT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define KQT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KQT_ASSERT(lbl, prop, msg)
`define KQT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: design/kqt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed quota table package
// Sizes, operation and status codes, and transaction types of the table.
// ----------------------------------------------------------------------------
package kqt_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 16;
  localparam int KEY_BITS      = 32;
  localparam int KEY_IN_W      = 32;
  localparam int KEY_W         = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // Amount arithmetic: 48-bit operands, 50-bit shared adder.
  localparam int AMT_W = 48;
  localparam int ALU_W = AMT_W + 2;

  // Operation codes.
  localparam logic [1:0] KIND_SET     = 2'd0;
  localparam logic [1:0] KIND_CHECK   = 2'd1;
  localparam logic [1:0] KIND_CONSUME = 2'd2;
  localparam logic [1:0] KIND_RELEASE = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  // Request transaction.
  typedef struct packed {
    logic [1:0]              kind;
    logic [KEY_IN_W-1:0]     key;
    logic signed [AMT_W-1:0] amount;
  } kqt_in_t;

  // Result transaction.
  typedef struct packed {
    logic [1:0] status;
    logic       allowed;
  } kqt_out_t;

  // Controls of the shared arithmetic unit.
  typedef struct packed {
    logic sub;         // subtract b from a rather than add
    logic clamp_zero;  // clamp negative results to zero before saturating
  } kqt_alu_ctl_t;

endpackage

FILE: design/kqt_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed quota table arithmetic unit
// Shared add/subtract with optional clamp at zero and saturation to the signed 48-bit amount range.
// ----------------------------------------------------------------------------
module kqt_alu (
  input  kqt_pkg::kqt_alu_ctl_t          ctl,
  input  logic signed [kqt_pkg::ALU_W-1:0] a,
  input  logic signed [kqt_pkg::ALU_W-1:0] b,
  output logic signed [kqt_pkg::ALU_W-1:0] res,
  output logic signed [kqt_pkg::AMT_W-1:0] sat
);
  import kqt_pkg::*;

  localparam logic signed [ALU_W-1:0] AMT_MAX_W = ALU_W'({1'b0, {(AMT_W-1){1'b1}}});
  localparam logic signed [ALU_W-1:0] AMT_MIN_W = -AMT_MAX_W - ALU_W'(1);

  // One wide add or subtract per use.
  assign res = ctl.sub ? (a - b) : (a + b);

  // Optional clamp at zero, then saturation to the 48-bit bounds.
  always_comb begin
    if (ctl.clamp_zero && res[ALU_W-1]) begin
      sat = '0;
    end else if (res > AMT_MAX_W) begin
      sat = AMT_MAX_W[AMT_W-1:0];
    end else if (res < AMT_MIN_W) begin
      sat = AMT_MIN_W[AMT_W-1:0];
    end else begin
      sat = res[AMT_W-1:0];
    end
  end

endmodule

FILE: design/keyed_quota_table.sv
`timescale 1ns / 1ps
// The result of an accepted request follows a key scan over the valid entries up to
// the match (all of them on a miss), then any check or update step.
// Throughput: one request at a time; the key scan reads one entry per cycle from the
// key memory, and checks take two passes through the shared adder.
// Reset: synchronous, active low; clears the fill count and all control state.
// ----------------------------------------------------------------------------
// Keyed quota table
// Key-searched table of limits and usages, queried and updated by set, check, consume and
// release requests under a small sequencer around one shared adder.
// ----------------------------------------------------------------------------
module keyed_quota_table (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kqt_pkg::kqt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output kqt_pkg::kqt_out_t out_data
);
  import kqt_pkg::*;

  `include "keyed_quota_table_assert.svh"

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CHK1 = 3'd2;
  localparam logic [2:0] S_CHK2 = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // Entry memories.
  logic [KEY_W-1:0]        key_mem [TABLE_ENTRIES];
  logic signed [AMT_W-1:0] lim_mem [TABLE_ENTRIES];
  logic signed [AMT_W-1:0] use_mem [TABLE_ENTRIES];

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic                    rd_v_r, rd_v_nxt;
  logic [IDX_W-1:0]        rd_idx_r;
  logic [KEY_W-1:0]        rd_key_r;
  logic signed [AMT_W-1:0] rd_lim_r;
  logic signed [AMT_W-1:0] rd_use_r;
  logic [1:0]              req_kind_r;
  logic [KEY_W-1:0]        req_key_r;
  logic signed [AMT_W-1:0] req_amt_r;
  logic signed [ALU_W-1:0] sum_r, sum_nxt;
  kqt_out_t                res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  kqt_out_t                out_data_r;

  logic                    in_fire;
  logic                    hit;
  logic                    rd_en;
  logic                    out_load;
  logic                    key_we, lim_we, use_we;
  logic [IDX_W-1:0]        wr_addr;
  logic signed [AMT_W-1:0] lim_wdata, use_wdata;

  kqt_alu_ctl_t            alu_ctl;
  logic signed [ALU_W-1:0] alu_a, alu_b, alu_res;
  logic signed [AMT_W-1:0] alu_sat;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A match is the registered read of the previous cycle.
  assign hit   = (state_r == S_SCAN) && rd_v_r && (rd_key_r == req_key_r);
  assign rd_en = (state_r == S_SCAN) && !hit && (idx_r < count_r);

  // Shared adder operands per step.
  always_comb begin
    alu_ctl = '0;
    alu_a   = ALU_W'(rd_use_r);
    alu_b   = ALU_W'(req_amt_r);
    case (state_r)
      S_CHK2: begin
        alu_ctl.sub = 1'b1;
        alu_a       = ALU_W'(rd_lim_r);
        alu_b       = sum_r;
      end
      S_UPD: begin
        alu_ctl.sub        = (req_kind_r == KIND_RELEASE);
        alu_ctl.clamp_zero = (req_kind_r == KIND_RELEASE);
      end
      default: begin
        alu_ctl = '0;
      end
    endcase
  end

  kqt_alu u_alu (
    .ctl (alu_ctl),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .sat (alu_sat)
  );

  // Sequencer and memory write control.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    rd_v_nxt  = rd_v_r;
    sum_nxt   = sum_r;
    res_nxt   = res_r;
    out_load  = 1'b0;
    key_we    = 1'b0;
    lim_we    = 1'b0;
    use_we    = 1'b0;
    wr_addr   = rd_idx_r;
    lim_wdata = req_amt_r;
    use_wdata = alu_sat;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
          rd_v_nxt  = 1'b0;
          res_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (hit) begin
          rd_v_nxt = 1'b0;
          case (req_kind_r)
            KIND_SET: begin
              lim_we    = 1'b1;
              state_nxt = S_DONE;
            end
            KIND_CHECK: begin
              state_nxt = S_CHK1;
            end
            default: begin
              state_nxt = S_UPD;
            end
          endcase
        end else if (rd_en) begin
          rd_v_nxt = 1'b1;
          idx_nxt  = idx_r + CNT_W'(1);
        end else begin
          // Every valid entry has been compared without a match.
          rd_v_nxt  = 1'b0;
          state_nxt = S_DONE;
          case (req_kind_r)
            KIND_SET: begin
              if (count_r >= CNT_W'(TABLE_ENTRIES)) begin
                res_nxt.status = STAT_FULL;
              end else begin
                wr_addr   = count_r[IDX_W-1:0];
                key_we    = 1'b1;
                lim_we    = 1'b1;
                use_we    = 1'b1;
                use_wdata = '0;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            KIND_CHECK: begin
              res_nxt.allowed = 1'b1;
            end
            default: begin
              res_nxt.status = STAT_NOT_FOUND;
            end
          endcase
        end
      end
      S_CHK1: begin
        sum_nxt   = alu_res;
        state_nxt = S_CHK2;
      end
      S_CHK2: begin
        res_nxt.allowed = !alu_res[ALU_W-1];
        state_nxt       = S_DONE;
      end
      S_UPD: begin
        use_we    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: holds a result until it is taken.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    res_r <= res_nxt;
    if (in_fire) begin
      req_kind_r <= in_data.kind;
      req_key_r  <= in_data.key[KEY_W-1:0];
      req_amt_r  <= in_data.amount;
    end
    if (out_load) begin
      out_data_r <= res_nxt;
    end
  end

  // Entry memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= req_key_r;
    end
    if (lim_we) begin
      lim_mem[wr_addr] <= lim_wdata;
    end
    if (use_we) begin
      use_mem[wr_addr] <= use_wdata;
    end
    if (rd_en) begin
      rd_idx_r <= idx_r[IDX_W-1:0];
      rd_key_r <= key_mem[idx_r[IDX_W-1:0]];
      rd_lim_r <= lim_mem[idx_r[IDX_W-1:0]];
      rd_use_r <= use_mem[idx_r[IDX_W-1:0]];
    end
  end

  // The fill count never passes the table size.
  `KQT_ASSERT(a_count_bound, count_r <= CNT_W'(TABLE_ENTRIES), "fill count exceeds table size")
  // The fill count only ever grows by one, and only on an append.
  `KQT_ASSERT(a_count_step, ($past(rst_n) && (count_r != $past(count_r))) |-> ((count_r == $past(count_r) + CNT_W'(1)) && ($past(state_r) == S_SCAN)), "fill count changed outside an append")
  // An accepted transaction always starts a key scan.
  `KQT_ASSERT(a_start_scan, in_fire |=> (state_r == S_SCAN), "accepted transaction did not start a scan")
  // A result is only loaded while the output slot is free or being emptied.
  `KQT_ASSERT(a_no_overwrite, out_load |-> (!out_valid_r || out_ready), "pending result overwritten")

endmodule
